>>> hw/rtl/fsp_pkg.sv
package fsp_pkg;

   // Characters that the parser recognizes.
   localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
   localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
   localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
   localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
   localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
   localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
   localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
   localparam logic [7:0] CH_LC_H  = 8'h68;  // 'h'
   localparam logic [7:0] CH_LC_L  = 8'h6C;  // 'l'
   localparam logic [7:0] CH_LC_J  = 8'h6A;  // 'j'
   localparam logic [7:0] CH_LC_Z  = 8'h7A;  // 'z'
   localparam logic [7:0] CH_LC_T  = 8'h74;  // 't'
   localparam logic [7:0] CH_UC_L  = 8'h4C;  // 'L'

   // Sign modes.
   localparam logic [1:0] SIGN_NONE  = 2'd0;
   localparam logic [1:0] SIGN_SPACE = 2'd1;
   localparam logic [1:0] SIGN_PLUS  = 2'd2;

   // Length modifier codes.
   localparam logic [3:0] LEN_NONE = 4'd0;
   localparam logic [3:0] LEN_H    = 4'd1;
   localparam logic [3:0] LEN_HH   = 4'd2;
   localparam logic [3:0] LEN_L    = 4'd3;
   localparam logic [3:0] LEN_LL   = 4'd4;
   localparam logic [3:0] LEN_J    = 4'd5;
   localparam logic [3:0] LEN_Z    = 4'd6;
   localparam logic [3:0] LEN_T    = 4'd7;
   localparam logic [3:0] LEN_BIG_L = 4'd8;

   localparam logic [15:0] SAT_MAX = 16'hFFFF;

   typedef struct packed {
      logic [7:0]         char_in;
      logic signed [31:0] star_arg;
   } req_type;

   typedef struct packed {
      logic        left_align;
      logic        alt_form;
      logic [1:0]  sign_mode;
      logic        zero_pad;
      logic [15:0] field_width;
      logic        prec_given;
      logic [15:0] precision;
      logic [3:0]  length_code;
      logic [7:0]  conversion;
   } rsp_type;

endpackage

>>> hw/rtl/format_spec_parser.sv
// Path: the conversion character is registered in the input register at its transfer, and the
// finished spec is loaded into the result register once that register has room for it.
// Throughput: one character per cycle; a conversion character waits only while the previous
// result is still stalled in the result register, and plain characters wait only behind it.
// Reset: synchronous, active high; clears the parse state and both valid flags.
module format_spec_parser
   import fsp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Parse phases. A byte that the current phase cannot take ends the spec.
   typedef enum logic [2:0] {
      PH_FLAGS   = 3'd0,   // start of spec, taking flags
      PH_WIDTH   = 3'd1,   // width digits
      PH_WSTAR   = 3'd2,   // after a width star
      PH_PREC    = 3'd3,   // precision digits
      PH_LEN     = 3'd4,   // length or conversion
      PH_AFTER_H = 3'd5,   // after a single 'h'
      PH_AFTER_L = 3'd6,   // after a single 'l'
      PH_CONV    = 3'd7    // conversion only
   } phase_type;

   // Input register: holds one character until the parse logic consumes it.
   logic    in_valid_ff;
   req_type in_ff;

   // Parse state.
   phase_type   phase_ff, phase_in;
   logic        alt_ff, alt_in;
   logic        left_ff, left_in;
   logic [1:0]  sign_ff, sign_in;
   logic        zero_ff, zero_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] prec_ff, prec_in;
   logic        prec_seen_ff, prec_seen_in;
   logic [3:0]  length_ff, length_in;

   // Result register.
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   logic [7:0]  c;
   logic        is_digit;
   logic        is_flag;
   logic        conv;
   logic        fire;
   logic        out_free;
   logic        star_neg;
   logic [15:0] star_sat;
   logic [3:0]  len_code;
   logic [19:0] width_x10;
   logic [19:0] prec_x10;
   logic [15:0] width_dig;
   logic [15:0] prec_dig;

   assign c        = in_ff.char_in;
   assign is_digit = c inside {[CH_ZERO:CH_NINE]};
   assign is_flag  = c inside {CH_HASH, CH_MINUS, CH_SPACE, CH_PLUS, CH_ZERO};

   // Star value: negative reads as zero, large positive values saturate.
   assign star_neg = in_ff.star_arg[31];
   assign star_sat = star_neg ? 16'd0 :
                     (|in_ff.star_arg[30:16]) ? SAT_MAX : in_ff.star_arg[15:0];

   // Decimal accumulation: acc * 10 + digit, as two shifts and adds, then saturate.
   // The digit value is the low nibble because the digits sit at 0x30 to 0x39.
   assign width_x10 = {1'b0, width_ff, 3'b000} + {3'b000, width_ff, 1'b0}
                      + {16'd0, c[3:0]};
   assign prec_x10  = {1'b0, prec_ff, 3'b000} + {3'b000, prec_ff, 1'b0}
                      + {16'd0, c[3:0]};
   assign width_dig = (|width_x10[19:16]) ? SAT_MAX : width_x10[15:0];
   assign prec_dig  = (|prec_x10[19:16]) ? SAT_MAX : prec_x10[15:0];

   always_comb begin
      case (c)
         CH_LC_H: len_code = LEN_H;
         CH_LC_L: len_code = LEN_L;
         CH_LC_J: len_code = LEN_J;
         CH_LC_Z: len_code = LEN_Z;
         CH_LC_T: len_code = LEN_T;
         CH_UC_L: len_code = LEN_BIG_L;
         default: len_code = LEN_NONE;
      endcase
   end

   // Next parse state for the character in the input register. The checks run in
   // priority order; whatever falls through all of them is the conversion character.
   always_comb begin
      phase_in     = phase_ff;
      alt_in       = alt_ff;
      left_in      = left_ff;
      sign_in      = sign_ff;
      zero_in      = zero_ff;
      width_in     = width_ff;
      prec_in      = prec_ff;
      prec_seen_in = prec_seen_ff;
      length_in    = length_ff;
      conv         = 1'b0;

      if (phase_ff == PH_FLAGS && is_flag) begin
         case (c)
            CH_HASH:  alt_in = 1'b1;
            CH_SPACE: sign_in = SIGN_SPACE;
            CH_PLUS:  sign_in = SIGN_PLUS;
            CH_MINUS: begin
               // Left alignment always overrides zero padding.
               left_in = 1'b1;
               zero_in = 1'b0;
            end
            default: begin
               // A zero flag has no effect once left alignment is set.
               if (!left_ff) begin
                  zero_in = 1'b1;
               end
            end
         endcase
      end else if ((phase_ff inside {PH_FLAGS, PH_WIDTH}) && is_digit) begin
         width_in = width_dig;
         phase_in = PH_WIDTH;
      end else if ((phase_ff inside {PH_FLAGS, PH_WIDTH}) && c == CH_STAR) begin
         // A star replaces any width digits already taken.
         width_in = star_sat;
         phase_in = PH_WSTAR;
      end else if ((phase_ff inside {PH_FLAGS, PH_WIDTH, PH_WSTAR}) && c == CH_DOT) begin
         prec_seen_in = 1'b1;
         prec_in      = 16'd0;
         phase_in     = PH_PREC;
      end else if (phase_ff == PH_PREC && is_digit) begin
         prec_in = prec_dig;
      end else if (phase_ff == PH_PREC && c == CH_STAR) begin
         // A negative precision star behaves as if no precision was given.
         prec_in = star_sat;
         if (star_neg) begin
            prec_seen_in = 1'b0;
         end
         phase_in = PH_LEN;
      end else if ((phase_ff inside {PH_FLAGS, PH_WIDTH, PH_WSTAR, PH_PREC, PH_LEN})
                   && len_code != LEN_NONE) begin
         length_in = len_code;
         phase_in  = (c == CH_LC_H) ? PH_AFTER_H :
                     (c == CH_LC_L) ? PH_AFTER_L : PH_CONV;
      end else if ((phase_ff == PH_AFTER_H && c == CH_LC_H) ||
                   (phase_ff == PH_AFTER_L && c == CH_LC_L)) begin
         // Doubled modifier: h becomes hh, l becomes ll.
         length_in = length_ff + 4'd1;
         phase_in  = PH_CONV;
      end else begin
         conv = 1'b1;
      end
   end

   // A plain character is always consumed. The conversion character needs room in
   // the result register, which frees up when its current result is transferred.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && (!conv || out_free);

   // The input register takes a new transfer whenever it is empty or being consumed.
   assign req_stall = in_valid_ff && !fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_FLAGS;
         alt_ff       <= 1'b0;
         left_ff      <= 1'b0;
         sign_ff      <= SIGN_NONE;
         zero_ff      <= 1'b0;
         width_ff     <= 16'd0;
         prec_ff      <= 16'd0;
         prec_seen_ff <= 1'b0;
         length_ff    <= LEN_NONE;
      end else begin
         if (req_valid && !req_stall) begin
            in_valid_ff <= 1'b1;
            in_ff       <= req_data;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end

         if (fire && conv) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         if (fire && conv) begin
            // Emit the finished spec and return to the start of a new one.
            rsp_ff.left_align  <= left_ff;
            rsp_ff.alt_form    <= alt_ff;
            rsp_ff.sign_mode   <= sign_ff;
            rsp_ff.zero_pad    <= zero_ff;
            rsp_ff.field_width <= width_ff;
            rsp_ff.prec_given  <= prec_seen_ff;
            rsp_ff.precision   <= prec_ff;
            rsp_ff.length_code <= length_ff;
            rsp_ff.conversion  <= c;
            phase_ff     <= PH_FLAGS;
            alt_ff       <= 1'b0;
            left_ff      <= 1'b0;
            sign_ff      <= SIGN_NONE;
            zero_ff      <= 1'b0;
            width_ff     <= 16'd0;
            prec_ff      <= 16'd0;
            prec_seen_ff <= 1'b0;
            length_ff    <= LEN_NONE;
         end else if (fire) begin
            phase_ff     <= phase_in;
            alt_ff       <= alt_in;
            left_ff      <= left_in;
            sign_ff      <= sign_in;
            zero_ff      <= zero_in;
            width_ff     <= width_in;
            prec_ff      <= prec_in;
            prec_seen_ff <= prec_seen_in;
            length_ff    <= length_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> dv/tb_format_spec_parser.sv
`timescale 1ns / 1ps

module tb_format_spec_parser;
   import fsp_pkg::*;

   // Clock, reset and the ports of the parser. Every input starts at a known value.
   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   format_spec_parser u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Parse phases of the predictor. They follow the order in which the parts of a
   // conversion spec may appear.
   typedef enum logic [2:0] {
      PH_FLAGS,     // start of a spec, flags accepted
      PH_WIDTH,     // width digits
      PH_WSTAR,     // width came from a star, no more width digits
      PH_PREC,      // precision digits
      PH_LEN,       // length modifier or conversion
      PH_AFTER_H,   // a second h makes hh
      PH_AFTER_L,   // a second l makes ll
      PH_CONV       // only the conversion is left
   } parse_phase_type;

   // Predictor state: the spec parsed so far.
   parse_phase_type spec_phase;
   logic         spec_alt;
   logic         spec_left;
   logic [1:0]   spec_sign;
   logic         spec_zero;
   logic [15:0]  spec_width;
   logic [15:0]  spec_prec;
   logic         spec_prec_on;
   logic [3:0]   spec_len;

   // Specs that the parser still owes, oldest first.
   rsp_type pending_specs[$];

   // Rates of idling, in percent, for the sender and the receiver.
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;

   int chars_sent    = 0;
   int specs_checked = 0;
   int errors        = 0;

   // Conversion characters that a real format string would normally use.
   string conv_chars = "diouxXfFeEgGaAcspn%";
   logic [7:0] flag_chars [5];

   initial begin
      flag_chars[0] = CH_HASH;
      flag_chars[1] = CH_MINUS;
      flag_chars[2] = CH_SPACE;
      flag_chars[3] = CH_PLUS;
      flag_chars[4] = CH_ZERO;
   end

   // Appends one decimal digit to a width or precision, saturating at the top of
   // the 16-bit range.
   function automatic logic [15:0] add_digit(input logic [15:0] acc, input logic [7:0] c);
      logic [31:0] v;
      v = 32'(acc) * 32'd10 + 32'(c - CH_ZERO);
      return (v > 32'(SAT_MAX)) ? SAT_MAX : v[15:0];
   endfunction

   // A star argument: negative values count as zero, large ones saturate.
   function automatic logic [15:0] star_to_count(input logic signed [31:0] s);
      if (s < 0)
         return 16'd0;
      else if (s > 32'sd65535)
         return SAT_MAX;
      else
         return s[15:0];
   endfunction

   function automatic logic [3:0] length_code_of(input logic [7:0] c);
      case (c)
         CH_LC_H: return LEN_H;
         CH_LC_L: return LEN_L;
         CH_LC_J: return LEN_J;
         CH_LC_Z: return LEN_Z;
         CH_LC_T: return LEN_T;
         CH_UC_L: return LEN_BIG_L;
         default: return LEN_NONE;
      endcase
   endfunction

   task automatic clear_spec();
      spec_phase   = PH_FLAGS;
      spec_alt     = 1'b0;
      spec_left    = 1'b0;
      spec_sign    = SIGN_NONE;
      spec_zero    = 1'b0;
      spec_width   = '0;
      spec_prec    = '0;
      spec_prec_on = 1'b0;
      spec_len     = LEN_NONE;
   endtask

   // Advances the predicted parse by one character. The first character that no
   // phase can take ends the spec, and the finished spec joins the queue.
   task automatic parse_char(input req_type r);
      logic [7:0] c;
      logic       is_digit;
      logic       is_flag;
      logic [3:0] len;
      rsp_type    spec;
      c        = r.char_in;
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      is_flag  = (c == CH_HASH) || (c == CH_MINUS) || (c == CH_SPACE) ||
                 (c == CH_PLUS) || (c == CH_ZERO);
      len      = length_code_of(c);
      if (spec_phase == PH_FLAGS && is_flag) begin
         if (c == CH_HASH) begin
            spec_alt = 1'b1;
         end else if (c == CH_SPACE || c == CH_PLUS) begin
            spec_sign = (c == CH_PLUS) ? SIGN_PLUS : SIGN_SPACE;
         end else if (c == CH_MINUS) begin
            // Left alignment rules out zero padding.
            spec_left = 1'b1;
            spec_zero = 1'b0;
         end else if (!spec_left) begin
            spec_zero = 1'b1;
         end
      end else if (spec_phase <= PH_WIDTH && is_digit) begin
         spec_width = add_digit(spec_width, c);
         spec_phase = PH_WIDTH;
      end else if (spec_phase <= PH_WIDTH && c == CH_STAR) begin
         spec_width = star_to_count(r.star_arg);
         spec_phase = PH_WSTAR;
      end else if (spec_phase <= PH_WSTAR && c == CH_DOT) begin
         spec_prec_on = 1'b1;
         spec_prec    = '0;
         spec_phase   = PH_PREC;
      end else if (spec_phase == PH_PREC && is_digit) begin
         spec_prec = add_digit(spec_prec, c);
      end else if (spec_phase == PH_PREC && c == CH_STAR) begin
         spec_prec = star_to_count(r.star_arg);
         if (r.star_arg < 0)
            spec_prec_on = 1'b0;
         spec_phase = PH_LEN;
      end else if (spec_phase <= PH_LEN && len != LEN_NONE) begin
         spec_len = len;
         if (c == CH_LC_H)
            spec_phase = PH_AFTER_H;
         else if (c == CH_LC_L)
            spec_phase = PH_AFTER_L;
         else
            spec_phase = PH_CONV;
      end else if ((spec_phase == PH_AFTER_H && c == CH_LC_H) ||
                   (spec_phase == PH_AFTER_L && c == CH_LC_L)) begin
         // hh and ll are the codes right after h and l.
         spec_len   = spec_len + 4'd1;
         spec_phase = PH_CONV;
      end else begin
         spec.left_align  = spec_left;
         spec.alt_form    = spec_alt;
         spec.sign_mode   = spec_sign;
         spec.zero_pad    = spec_zero;
         spec.field_width = spec_width;
         spec.prec_given  = spec_prec_on;
         spec.precision   = spec_prec;
         spec.length_code = spec_len;
         spec.conversion  = c;
         pending_specs.push_back(spec);
         clear_spec();
      end
   endtask

   // Every accepted character is fed to the predictor at the edge of its transfer.
   always @(posedge clock) begin
      if (reset)
         clear_spec();
      else if (req_valid && !req_stall)
         parse_char(req_data);
   end

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   // Each spec that leaves the parser is compared field by field with the oldest
   // one that the predictor produced.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_specs.size() == 0) begin
            $display("%0t: unexpected spec, expected none, actual %h", $time, rsp_data);
            errors++;
         end else begin
            want = pending_specs.pop_front();
            check_field("left_align", 16'(want.left_align), 16'(rsp_data.left_align));
            check_field("alt_form", 16'(want.alt_form), 16'(rsp_data.alt_form));
            check_field("sign_mode", 16'(want.sign_mode), 16'(rsp_data.sign_mode));
            check_field("zero_pad", 16'(want.zero_pad), 16'(rsp_data.zero_pad));
            check_field("field_width", want.field_width, rsp_data.field_width);
            check_field("prec_given", 16'(want.prec_given), 16'(rsp_data.prec_given));
            check_field("precision", want.precision, rsp_data.precision);
            check_field("length_code", 16'(want.length_code), 16'(rsp_data.length_code));
            check_field("conversion", 16'(want.conversion), 16'(rsp_data.conversion));
            specs_checked++;
         end
      end
   end

   // The receiver stalls at random, at the rate that the current phase sets.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);
   end

   // Presents one character and returns at the edge of its transfer. Idle cycles go
   // in front of it at the sender's rate; valid is never lowered and raised again
   // within one time step.
   task automatic send_char(input logic [7:0] c, input logic [31:0] star);
      req_type item;
      item.char_in  = c;
      item.star_arg = star;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do
         @(posedge clock);
      while (req_stall);
      chars_sent++;
   endtask

   // The sender holds back until every spec owed has come out. The first edge lets
   // the predictor take the last transfer before the queue is looked at.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_specs.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Star arguments: small, saturating, the edges of the signed range and
   // negatives, so that both the width and the precision rules are reached.
   function automatic logic [31:0] pick_star();
      case ($urandom_range(5))
         0:       return 32'($urandom_range(40));
         1:       return $urandom;
         2:       return -32'($urandom_range(100, 1));
         3:       return 32'h8000_0000;
         4:       return 32'd65534 + 32'($urandom_range(2));
         default: return 32'h7FFF_FFFF;
      endcase
   endfunction

   // Sends one random spec. Most are well formed, with random flags, width,
   // precision and length; the rest are stray bytes that may land in any phase.
   task automatic send_random_spec();
      int n;
      int pick;
      if ($urandom_range(99) < 12) begin
         n = $urandom_range(3, 1);
         repeat (n) send_char(8'($urandom_range(255)), $urandom);
         return;
      end
      n = ($urandom_range(1) == 0) ? 0 : $urandom_range(4, 1);
      repeat (n) send_char(flag_chars[$urandom_range(4)], $urandom);
      case ($urandom_range(2))
         1: begin
            n = ($urandom_range(9) == 0) ? 6 : $urandom_range(3, 1);
            send_char(CH_ZERO + 8'($urandom_range(9, 1)), $urandom);
            repeat (n - 1) send_char(CH_ZERO + 8'($urandom_range(9)), $urandom);
         end
         2: send_char(CH_STAR, pick_star());
         default: ;
      endcase
      if ($urandom_range(1) == 0) begin
         send_char(CH_DOT, $urandom);
         case ($urandom_range(2))
            1: begin
               n = ($urandom_range(9) == 0) ? 6 : $urandom_range(3, 1);
               repeat (n) send_char(CH_ZERO + 8'($urandom_range(9)), $urandom);
            end
            2: send_char(CH_STAR, pick_star());
            default: ;
         endcase
      end
      pick = $urandom_range(11);
      case (pick)
         1: send_char(CH_LC_H, $urandom);
         2: begin
            send_char(CH_LC_H, $urandom);
            send_char(CH_LC_H, $urandom);
         end
         3: send_char(CH_LC_L, $urandom);
         4: begin
            send_char(CH_LC_L, $urandom);
            send_char(CH_LC_L, $urandom);
         end
         5: send_char(CH_LC_J, $urandom);
         6: send_char(CH_LC_Z, $urandom);
         7: send_char(CH_LC_T, $urandom);
         8: send_char(CH_UC_L, $urandom);
         default: ;
      endcase
      if ($urandom_range(3) == 0)
         send_char(8'($urandom_range(255)), $urandom);
      else
         send_char(conv_chars[$urandom_range(conv_chars.len() - 1)], $urandom);
   endtask

   // All five flags in one spec: the zero flag is set, cleared by the minus and then
   // ignored after it, and a space after a plus leaves the space mode in force.
   task automatic test_flag_rules();
      send_char(CH_HASH, $urandom);
      send_char(CH_PLUS, $urandom);
      send_char(CH_ZERO, $urandom);
      send_char(CH_MINUS, $urandom);
      send_char(CH_ZERO, $urandom);
      send_char(CH_SPACE, $urandom);
      send_char("d", $urandom);
   endtask

   // A width just past saturation with the largest positive star as precision and
   // hh; then a star that overrides digits with a negative value, a negative
   // precision star, and an L followed by a stray l as the conversion.
   task automatic test_width_and_precision();
      send_char("6", $urandom);
      send_char("5", $urandom);
      send_char("5", $urandom);
      send_char("3", $urandom);
      send_char("6", $urandom);
      send_char(CH_DOT, $urandom);
      send_char(CH_STAR, 32'h7FFF_FFFF);
      send_char(CH_LC_H, $urandom);
      send_char(CH_LC_H, $urandom);
      send_char("i", $urandom);
      send_char("5", $urandom);
      send_char(CH_STAR, -32'sd9);
      send_char(CH_DOT, $urandom);
      send_char(CH_STAR, -32'sd1);
      send_char(CH_UC_L, $urandom);
      send_char(CH_LC_L, $urandom);
   endtask

   // Bytes out of place end the spec: a flag after a width, a second dot, and a
   // zero byte at the very start.
   task automatic test_stray_characters();
      send_char("3", $urandom);
      send_char(CH_HASH, $urandom);
      send_char(CH_DOT, $urandom);
      send_char(CH_DOT, $urandom);
      send_char(8'h00, $urandom);
   endtask

   task automatic test_random_specs(input int count, input int tx_pct, input int rx_pct);
      int target;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      target = chars_sent + count;
      while (chars_sent < target)
         send_random_spec();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed cases run under the first idle mix: a mostly busy sender and a
      // receiver that stalls often.
      tx_idle_pct = 9;
      rx_idle_pct = 62;
      test_flag_rules();
      test_width_and_precision();
      test_stray_characters();
      hold_until_drained();

      // Random specs under three idle mixes, with a full drain between them.
      test_random_specs(205, 9, 62);
      hold_until_drained();
      test_random_specs(205, 62, 9);
      hold_until_drained();
      test_random_specs(205, 0, 0);
      hold_until_drained();

      $display("Sent %0d format characters and checked %0d complete specs", chars_sent,
               specs_checked);
      $display("across directed flag, width, precision and stray-byte cases and three idle mixes.");
      if (errors == 0)
         $display("tb_format_spec_parser OK");
      else
         $display("tb_format_spec_parser NOT OK");
      $finish;
   end

   // Guard against a hang: far beyond the slowest correct run.
   initial begin
      #3_000_000;
      $display("Timeout with %0d specs still owed", pending_specs.size());
      $display("tb_format_spec_parser NOT OK");
      $finish;
   end

endmodule
